>>> design/n2a_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// n2a_pkg
// Shared types, constants and helpers for the binary to ASCII digit converter.
// -----------------------------------------------------------------------------
package n2a_pkg;

    localparam int unsigned IN_WIDTH      = 32;
    localparam int unsigned CHAR_WIDTH    = 7;
    localparam int unsigned DIGIT_WIDTH   = 4;
    localparam int unsigned VALUE_WIDTH   = 32;
    localparam int unsigned MAX_DIGITS    = 10;
    localparam int unsigned IDX_WIDTH     = $clog2(MAX_DIGITS);
    localparam int unsigned HEX_SHIFT     = 4;

    // Reciprocal of ten: q = (v * RECIP) >> RECIP_SHIFT is exact for any
    // value below 2**32.
    localparam int unsigned     RECIP_WIDTH = 32;
    localparam int unsigned     RECIP_SHIFT = 35;
    localparam logic [31:0]     RECIP       = 32'hCCCC_CCCD;

    localparam logic [DIGIT_WIDTH-1:0] DEC_RADIX   = 4'd10;
    localparam logic [CHAR_WIDTH-1:0]  DIGIT_BASE  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0]  LETTER_BASE = 7'd87;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_DIGIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic prime;
        logic step;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic idx_zero;
    } t_status;

    function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(
        input logic [DIGIT_WIDTH-1:0] digit
    );
        logic [CHAR_WIDTH-1:0] ext;
        ext = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, digit};
        if (digit < DEC_RADIX) begin
            return ext + DIGIT_BASE;
        end
        return ext + LETTER_BASE;
    endfunction

endpackage
`default_nettype wire

>>> design/n2a_in_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// n2a_in_if
// Input channel: one number and its radix flag per transfer.
// -----------------------------------------------------------------------------
interface n2a_in_if;
    logic                            valid;
    logic                            ready;
    logic [n2a_pkg::IN_WIDTH-1:0]    value;
    logic                            hex_mode;

    modport source (output valid, output value, output hex_mode, input ready);
    modport sink   (input valid, input value, input hex_mode, output ready);
endinterface
`default_nettype wire

>>> design/n2a_out_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// n2a_out_if
// Output channel: one ASCII digit per transfer, with a last-digit mark.
// -----------------------------------------------------------------------------
interface n2a_out_if;
    logic                            valid;
    logic                            ready;
    logic [n2a_pkg::CHAR_WIDTH-1:0]  char_code;
    logic                            last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

>>> design/n2a_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// n2a_ctrl
// Sequencer: accepts a number, runs the digit extraction, then emits digits.
// -----------------------------------------------------------------------------
module n2a_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  n2a_pkg::t_status    i_status,
    output n2a_pkg::t_cmd       o_cmd
);

    n2a_pkg::t_state r_state;
    n2a_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= n2a_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            n2a_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = n2a_pkg::ST_PRIME;
                end
            end
            n2a_pkg::ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = n2a_pkg::ST_DIGIT;
            end
            n2a_pkg::ST_DIGIT: begin
                o_cmd.step = 1'b1;
                if (i_status.done) begin
                    n_state = n2a_pkg::ST_EMIT;
                end
            end
            n2a_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = n2a_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = n2a_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/n2a_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// n2a_dp
// Datapath: reciprocal divide by ten or nibble shift, digit buffer, ASCII map.
// -----------------------------------------------------------------------------
module n2a_dp #(
    parameter int unsigned VALUE_WIDTH = n2a_pkg::VALUE_WIDTH
) (
    input  wire                                 i_clk,
    input  wire [n2a_pkg::IN_WIDTH-1:0]         i_value,
    input  wire                                 i_hex_mode,
    input  n2a_pkg::t_cmd                       i_cmd,
    output n2a_pkg::t_status                    o_status,
    output logic [n2a_pkg::CHAR_WIDTH-1:0]      o_char_code,
    output logic                                o_last
);

    localparam int unsigned PROD_WIDTH = VALUE_WIDTH + n2a_pkg::RECIP_WIDTH;
    localparam int unsigned DW         = n2a_pkg::DIGIT_WIDTH;
    localparam int unsigned IW         = n2a_pkg::IDX_WIDTH;
    localparam logic [IW-1:0] LAST_IDX = IW'(n2a_pkg::MAX_DIGITS - 1);

    logic [VALUE_WIDTH-1:0]     r_v;
    logic [PROD_WIDTH-1:0]      r_prod;
    logic                       r_hex;
    logic [IW-1:0]              r_idx;
    logic [DW-1:0]              r_digits [n2a_pkg::MAX_DIGITS];

    logic [VALUE_WIDTH-1:0]     q_dec;
    logic [VALUE_WIDTH-1:0]     q_hex;
    logic [VALUE_WIDTH-1:0]     q_sel;
    logic [VALUE_WIDTH+3:0]     ten_q;
    logic [VALUE_WIDTH+3:0]     diff;
    logic [DW-1:0]              rem_sel;
    logic [PROD_WIDTH-1:0]      prod_in;
    logic                       done;

    assign q_dec   = VALUE_WIDTH'(r_prod >> n2a_pkg::RECIP_SHIFT);
    assign q_hex   = r_v >> n2a_pkg::HEX_SHIFT;
    assign ten_q   = ({4'd0, q_dec} << 3) + ({4'd0, q_dec} << 1);
    assign diff    = {4'd0, r_v} - ten_q;
    assign q_sel   = r_hex ? q_hex : q_dec;
    assign rem_sel = r_hex ? r_v[DW-1:0] : diff[DW-1:0];
    assign done    = (q_sel == '0) || (r_idx == LAST_IDX);

    always_comb begin
        if (i_cmd.prime) begin
            prod_in = PROD_WIDTH'(r_v) * PROD_WIDTH'(n2a_pkg::RECIP);
        end else begin
            prod_in = PROD_WIDTH'(q_dec) * PROD_WIDTH'(n2a_pkg::RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v   <= i_value[VALUE_WIDTH-1:0];
            r_hex <= i_hex_mode;
            r_idx <= '0;
        end
        if (i_cmd.prime || i_cmd.step) begin
            r_prod <= prod_in;
        end
        if (i_cmd.step) begin
            r_digits[r_idx] <= rem_sel;
            r_v             <= q_sel;
            if (!done) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.pop && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign o_status.done     = done;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_char_code       = n2a_pkg::digit_to_ascii(r_digits[r_idx]);
    assign o_last            = (r_idx == '0);

endmodule
`default_nettype wire

>>> design/number_to_ascii_digits_top.sv
`default_nettype none
// Sequence: after an input transfer the block primes the divider, extracts N
// digits with the single divide-by-ten/shift unit, then offers them one digit
// per cycle while the output is ready, where N is the digit count (1 to 10).
// A new number is accepted only in idle, after the last digit has transferred.
// Reset: synchronous active-low reset returns the sequencer to idle.
// -----------------------------------------------------------------------------
// number_to_ascii_digits_top
// Converts an unsigned number to decimal or lower-case hex ASCII digits.
// -----------------------------------------------------------------------------
module number_to_ascii_digits_top #(
    parameter int unsigned VALUE_WIDTH = n2a_pkg::VALUE_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    n2a_in_if.sink      i_in,
    n2a_out_if.source   o_out
);

    n2a_pkg::t_cmd      cmd;
    n2a_pkg::t_status   status;

    n2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    n2a_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_value     (i_in.value),
        .i_hex_mode  (i_in.hex_mode),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_char_code (o_out.char_code),
        .o_last      (o_out.last)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// This testbench checks the number to ASCII digit converter. Each number is
// sent through the input channel. A built-in digit predictor queues the
// characters the block should produce. Every output transfer is checked
// against the oldest queued character. Both channels idle and stall at
// random. One phase holds the output off long enough to back up the input.
// -----------------------------------------------------------------------------
module tb_top;

    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;
    localparam int   RANDOM_ITEMS = 76;
    localparam int   HOLD_CYCLES = 300;
    localparam int   TAIL_CYCLES = 40;
    localparam int   CYCLE_LIMIT = 200000;

    typedef struct {
        logic [n2a_pkg::CHAR_WIDTH-1:0] char_code;
        logic                           last;
    } t_digit_exp;

    logic i_clk;
    logic i_rst_n;

    n2a_in_if  in_if();
    n2a_out_if out_if();

    number_to_ascii_digits_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_digit_exp  expected_digits[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          hold_req = 0;
    bit          hold_active = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_phase = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Queues the characters of one number, most significant digit first.
    function automatic void predict_digits(logic [n2a_pkg::IN_WIDTH-1:0] value,
                                           logic hex_mode);
        logic [63:0]           rest;
        logic [63:0]           radix;
        logic [63:0]           rev [n2a_pkg::MAX_DIGITS];
        int                    count;
        t_digit_exp            exp_digit;
        rest = {32'd0, value} & ((64'd1 << n2a_pkg::VALUE_WIDTH) - 64'd1);
        radix = (hex_mode == RADIX_HEX) ? 64'd16 : 64'd10;
        count = 0;
        do begin
            rev[count] = rest % radix;
            rest = rest / radix;
            count++;
        end while (rest != 0 && count < n2a_pkg::MAX_DIGITS);
        for (int k = 0; k < count; k++) begin
            if (rev[count-1-k] < 10) begin
                exp_digit.char_code = rev[count-1-k][n2a_pkg::CHAR_WIDTH-1:0]
                                      + n2a_pkg::DIGIT_BASE;
            end else begin
                exp_digit.char_code = rev[count-1-k][n2a_pkg::CHAR_WIDTH-1:0]
                                      + n2a_pkg::LETTER_BASE;
            end
            exp_digit.last = (k == count - 1);
            expected_digits.push_back(exp_digit);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_number(logic [n2a_pkg::IN_WIDTH-1:0] value, logic hex_mode);
        in_if.valid    <= 1'b1;
        in_if.value    <= value;
        in_if.hex_mode <= hex_mode;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        predict_digits(value, hex_mode);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (expected_digits.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [n2a_pkg::IN_WIDTH-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (stall_phase == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        stall_phase <= (stall_phase + 1) % 64;
        if (hold_active) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= stall_pattern[stall_phase % 16];
        end
    end

    always begin
        wait (hold_req);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_active = 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin
        t_digit_exp exp_digit;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_digits.size() == 0) begin
                $error("unexpected transfer: char_code %0d, last %0b",
                       out_if.char_code, out_if.last);
                error_count++;
            end else begin
                exp_digit = expected_digits.pop_front();
                if (out_if.char_code !== exp_digit.char_code) begin
                    $error("char_code mismatch: expected %0d, actual %0d",
                           exp_digit.char_code, out_if.char_code);
                    error_count++;
                end
                if (out_if.last !== exp_digit.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           exp_digit.last, out_if.last);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [n2a_pkg::IN_WIDTH-1:0] values [12];
        values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd15, 32'd16, 32'd255,
                   32'd999999999, 32'd1000000000, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'hABCD_EF12};
        foreach (values[i]) begin
            send_number(values[i], RADIX_DEC);
            send_number(values[i], RADIX_HEX);
        end
    endtask

    task automatic test_random_numbers(int count);
        repeat (count) begin
            sender_gap();
            send_number(random_value(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        repeat (30) begin
            send_number(random_value(), 1'($urandom_range(0, 1)));
        end
        wait_for_drain();
    endtask

    task automatic test_pause_for_drain();
        repeat (10) begin
            sender_gap();
            send_number(random_value(), 1'($urandom_range(0, 1)));
        end
        wait_for_drain();
        repeat (10) begin
            send_number(random_value(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.value    = '0;
        in_if.hex_mode = RADIX_DEC;
        out_if.ready   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_output_hold();
        test_random_numbers(RANDOM_ITEMS / 2);
        test_pause_for_drain();
        test_random_numbers(RANDOM_ITEMS / 2);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_digits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
